### design/bidf_pkg.sv
// Shared types and constants for the bytecode instruction deframer.
// Holds the configuration and record structs, argument kind codes and register indexes.
// No dependencies; every other design file refers to it by scoped names.
package bidf_pkg;

    // Opcodes at or above this value are outside the opcode table.
    localparam int TABLE_SIZE = 17;
    localparam logic [7:0] TABLE_LIMIT = 8'(TABLE_SIZE);

    // Per-opcode configuration covers this many opcodes.
    localparam int MASK_BITS = 17;
    localparam int COUNT_BITS = 2 * MASK_BITS;
    localparam logic [7:0] MASK_LIMIT = 8'(MASK_BITS);

    // Configuration port geometry.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 64;

    // Register indexes, taken from paddr[4:3].
    localparam logic [1:0] REG_HAS_ENCODING = 2'd0;
    localparam logic [1:0] REG_SHORT_DIRECT = 2'd1;
    localparam logic [1:0] REG_ARG_COUNT = 2'd2;

    // Argument kind codes.
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_REGISTER = 2'd1;
    localparam logic [1:0] KIND_DIRECT = 2'd2;
    localparam logic [1:0] KIND_INDIRECT = 2'd3;

    typedef struct packed {
        logic [MASK_BITS-1:0]  has_encoding_mask;
        logic [MASK_BITS-1:0]  short_direct_mask;
        logic [COUNT_BITS-1:0] arg_count_table;
    } cfg_t;

    typedef struct packed {
        logic [7:0]         opcode;
        logic [1:0]         arg_count;
        logic [1:0]         kind_a;
        logic signed [31:0] value_a;
        logic [1:0]         kind_b;
        logic signed [31:0] value_b;
        logic [1:0]         kind_c;
        logic signed [31:0] value_c;
        logic               bad_opcode;
    } record_t;

    // Handoff from the parser to the result register.
    typedef struct packed {
        logic    load;
        record_t rec;
    } rec_push_t;

endpackage

### design/bidf_regs.sv
// Configuration registers of the bytecode instruction deframer behind an APB-style port.
// Depends on bidf_pkg for the register indexes and the cfg_t struct.
module bidf_regs
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bidf_pkg::ADDR_W-1:0] paddr,
    input  logic [bidf_pkg::DATA_W-1:0] pwdata,
    output logic [bidf_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output bidf_pkg::cfg_t             cfg
);

    logic [bidf_pkg::MASK_BITS-1:0]  has_enc_reg;
    logic [bidf_pkg::MASK_BITS-1:0]  short_dir_reg;
    logic [bidf_pkg::COUNT_BITS-1:0] count_tab_reg;
    logic [1:0]                      reg_index;
    logic                            wr_en;

    assign pready = 1'b1;
    assign reg_index = paddr[bidf_pkg::ADDR_W-1:bidf_pkg::ADDR_W-2];
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_enc_reg <= '0;
            short_dir_reg <= '0;
            count_tab_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_index)
                bidf_pkg::REG_HAS_ENCODING:
                    has_enc_reg <= pwdata[bidf_pkg::MASK_BITS-1:0];
                bidf_pkg::REG_SHORT_DIRECT:
                    short_dir_reg <= pwdata[bidf_pkg::MASK_BITS-1:0];
                bidf_pkg::REG_ARG_COUNT:
                    count_tab_reg <= pwdata[bidf_pkg::COUNT_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            bidf_pkg::REG_HAS_ENCODING:
                prdata = bidf_pkg::DATA_W'(has_enc_reg);
            bidf_pkg::REG_SHORT_DIRECT:
                prdata = bidf_pkg::DATA_W'(short_dir_reg);
            bidf_pkg::REG_ARG_COUNT:
                prdata = bidf_pkg::DATA_W'(count_tab_reg);
            default:
                prdata = '0;
        endcase
    end

    assign cfg.has_encoding_mask = has_enc_reg;
    assign cfg.short_direct_mask = short_dir_reg;
    assign cfg.arg_count_table = count_tab_reg;

endmodule

### design/bidf_parser.sv
// Input byte register and instruction parser state of the bytecode instruction deframer.
// Depends on bidf_pkg for the configuration, record and handoff structs.
module bidf_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                stream_valid,
    output logic                stream_ready,
    input  logic [7:0]          stream_byte,
    input  bidf_pkg::cfg_t      cfg,
    input  logic                room,
    output bidf_pkg::rec_push_t push
);

    typedef enum logic [1:0] {
        PH_OPCODE,
        PH_ENCODING,
        PH_ARGS
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  byte_reg;
    logic        full_reg;
    logic [7:0]  op_reg, op_next;
    logic [7:0]  enc_reg, enc_next;
    logic [1:0]  slot_reg, slot_next;
    logic [2:0]  left_reg, left_next;
    logic [1:0]  kinds_reg [3];
    logic [1:0]  kinds_next [3];
    logic [31:0] vals_reg [3];
    logic [31:0] vals_next [3];

    logic        emit;
    logic        bad;
    logic        seek;
    logic [1:0]  seek_from;
    logic [1:0]  count;
    logic        found;
    logic [1:0]  kind;
    logic [1:0]  s;
    logic [2:0]  left_dec;
    logic        fire;

    function automatic logic uses_encoding(input logic [7:0] op,
                                           input logic [bidf_pkg::MASK_BITS-1:0] mask);
        logic r;
        r = (op != 8'd0) && (op < bidf_pkg::TABLE_LIMIT) && (op < bidf_pkg::MASK_LIMIT)
            && mask[op[4:0]];
        return r;
    endfunction

    function automatic logic short_direct(input logic [7:0] op,
                                          input logic [bidf_pkg::MASK_BITS-1:0] mask);
        logic r;
        r = (op < bidf_pkg::MASK_LIMIT) && mask[op[4:0]];
        return r;
    endfunction

    always_comb
    begin
        phase_next = phase_reg;
        op_next = op_reg;
        enc_next = enc_reg;
        slot_next = slot_reg;
        left_next = left_reg;
        kinds_next = kinds_reg;
        vals_next = vals_reg;
        emit = 1'b0;
        bad = 1'b0;
        seek = 1'b0;
        seek_from = 2'd0;
        s = slot_reg;
        left_dec = (left_reg != 3'd0) ? left_reg - 3'd1 : 3'd0;

        if (phase_reg == PH_ENCODING)
        begin
            enc_next = byte_reg;
            slot_next = 2'd0;
            seek = 1'b1;
        end
        else if (phase_reg == PH_ARGS && slot_reg != 2'd3)
        begin
            vals_next[s] = {vals_reg[s][23:0], byte_reg};
            left_next = left_dec;
            if (left_dec == 3'd0)
            begin
                if (kinds_reg[s] == bidf_pkg::KIND_INDIRECT
                    || (kinds_reg[s] == bidf_pkg::KIND_DIRECT
                        && short_direct(op_reg, cfg.short_direct_mask)))
                begin
                    vals_next[s] = {{16{vals_next[s][15]}}, vals_next[s][15:0]};
                end
                slot_next = slot_reg + 2'd1;
                seek_from = slot_reg + 2'd1;
                seek = 1'b1;
            end
        end
        else
        begin
            // Any other phase code, including the unused one, expects an opcode.
            op_next = byte_reg;
            enc_next = 8'd0;
            slot_next = 2'd0;
            left_next = 3'd0;
            for (int k = 0; k < 3; k++)
            begin
                kinds_next[k] = bidf_pkg::KIND_NONE;
                vals_next[k] = '0;
            end
            phase_next = PH_OPCODE;
            if (byte_reg >= bidf_pkg::TABLE_LIMIT)
            begin
                emit = 1'b1;
                bad = 1'b1;
            end
            else if (uses_encoding(byte_reg, cfg.has_encoding_mask))
            begin
                phase_next = PH_ENCODING;
            end
            else
            begin
                // Without an encoding byte the instruction has one direct argument.
                enc_next = 8'h80;
                seek = 1'b1;
            end
        end

        // Argument count follows the opcode that is being held after this byte.
        if (uses_encoding(op_next, cfg.has_encoding_mask))
            count = cfg.arg_count_table[{op_next[4:0], 1'b0} +: 2];
        else
            count = 2'd1;

        // Find the next slot that needs bytes; empty slots are passed over.
        found = 1'b0;
        kind = bidf_pkg::KIND_NONE;
        if (seek)
        begin
            for (int j = 0; j < 3; j++)
            begin
                kind = enc_next[6-2*j +: 2];
                if (!found && 2'(j) >= seek_from && 2'(j) < count)
                begin
                    kinds_next[j] = kind;
                    vals_next[j] = '0;
                    if (kind != bidf_pkg::KIND_NONE)
                    begin
                        found = 1'b1;
                        slot_next = 2'(j);
                        phase_next = PH_ARGS;
                        if (kind == bidf_pkg::KIND_REGISTER)
                            left_next = 3'd1;
                        else if (kind == bidf_pkg::KIND_DIRECT
                                 && !short_direct(op_next, cfg.short_direct_mask))
                            left_next = 3'd4;
                        else
                            left_next = 3'd2;
                    end
                end
            end
            if (!found)
            begin
                emit = 1'b1;
                phase_next = PH_OPCODE;
            end
        end
    end

    assign fire = full_reg && (!emit || room);
    assign stream_ready = !full_reg || fire;

    assign push.load = fire && emit;
    assign push.rec.opcode = op_next;
    assign push.rec.arg_count = bad ? 2'd0 : count;
    assign push.rec.kind_a = kinds_next[0];
    assign push.rec.value_a = $signed(vals_next[0]);
    assign push.rec.kind_b = kinds_next[1];
    assign push.rec.value_b = $signed(vals_next[1]);
    assign push.rec.kind_c = kinds_next[2];
    assign push.rec.value_c = $signed(vals_next[2]);
    assign push.rec.bad_opcode = bad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            byte_reg <= '0;
            phase_reg <= PH_OPCODE;
            op_reg <= '0;
            enc_reg <= '0;
            slot_reg <= '0;
            left_reg <= '0;
            for (int k = 0; k < 3; k++)
            begin
                kinds_reg[k] <= bidf_pkg::KIND_NONE;
                vals_reg[k] <= '0;
            end
        end
        else
        begin
            if (stream_valid && stream_ready)
            begin
                byte_reg <= stream_byte;
                full_reg <= 1'b1;
            end
            else if (fire)
            begin
                full_reg <= 1'b0;
            end
            if (fire)
            begin
                phase_reg <= phase_next;
                op_reg <= op_next;
                enc_reg <= enc_next;
                slot_reg <= slot_next;
                left_reg <= left_next;
                kinds_reg <= kinds_next;
                vals_reg <= vals_next;
            end
        end
    end

    a_args_have_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ARGS |-> left_reg != 3'd0)
        else $error("argument phase entered with no bytes left");

    a_args_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ARGS |-> slot_reg != 2'd3)
        else $error("argument phase with slot index past the last slot");

    a_bad_record_empty: assert property (@(posedge clk) disable iff (!rst_n)
        push.load && push.rec.bad_opcode |->
            push.rec.arg_count == 2'd0 && push.rec.kind_a == bidf_pkg::KIND_NONE
            && $past(phase_reg) == $past(phase_reg) && op_next >= bidf_pkg::TABLE_LIMIT)
        else $error("bad opcode record carries arguments or an in-table opcode");

    a_no_load_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push.load |-> room)
        else $error("record pushed while the result register cannot take it");

endmodule

### design/bidf_outreg.sv
// Result register of the bytecode instruction deframer, holding one record for the receiver.
// Depends on bidf_pkg for the record and handoff structs.
module bidf_outreg
(
    input  logic                clk,
    input  logic                rst_n,
    input  bidf_pkg::rec_push_t push,
    output logic                room,
    output logic                record_valid,
    input  logic                record_ready,
    output bidf_pkg::record_t   rec
);

    logic              valid_reg;
    bidf_pkg::record_t rec_reg;

    // A new record may enter when the register is empty or is being drained this cycle.
    assign room = !valid_reg || record_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push.load)
        begin
            valid_reg <= 1'b1;
        end
        else if (record_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.load)
        begin
            rec_reg <= push.rec;
        end
    end

    assign record_valid = valid_reg;
    assign rec = rec_reg;

endmodule

### design/bytecode_instruction_deframer_unit.sv
// Bytecode instruction deframer, top level.
// Instantiates bidf_regs, bidf_parser and bidf_outreg; depends on bidf_pkg.
//
// Usage:
// The stream channel (stream_valid, stream_ready, stream_byte) carries one byte of a
// big-endian bytecode stream per word. The record channel (record_valid, record_ready
// and the record fields) carries one word per complete instruction: the opcode, the
// argument count, and the kind and value of up to three arguments. An opcode outside
// the opcode table produces a record at once with bad_opcode set and no arguments.
// A trailing instruction that never completes produces no record.
// The per-opcode tables sit in three 64-bit registers at byte addresses 0, 8 and 16
// of the APB-style port; they should be written only while the block is idle.
// A byte lands in the input register at the edge that accepts it and is parsed from there
// by the combinational parser step, which loads the record of an instruction into the
// result register when it parses the last byte. Throughput is one byte per cycle while
// the result register has room, set by the parser step between the two registers.
// When the receiver stalls, the result register holds its record; bytes that produce
// no record keep flowing, and the first byte that would produce a second record waits
// in the input register, which then holds stream_ready low.
// Reset clears the tables, the parser state and both valid flags.
module bytecode_instruction_deframer_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bidf_pkg::ADDR_W-1:0] paddr,
    input  logic [bidf_pkg::DATA_W-1:0] pwdata,
    output logic [bidf_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        stream_valid,
    output logic                        stream_ready,
    input  logic [7:0]                  stream_byte,
    output logic                        record_valid,
    input  logic                        record_ready,
    output logic [7:0]                  opcode,
    output logic [1:0]                  arg_count,
    output logic [1:0]                  kind_a,
    output logic signed [31:0]          value_a,
    output logic [1:0]                  kind_b,
    output logic signed [31:0]          value_b,
    output logic [1:0]                  kind_c,
    output logic signed [31:0]          value_c,
    output logic                        bad_opcode
);

    bidf_pkg::cfg_t      cfg;
    bidf_pkg::rec_push_t push;
    bidf_pkg::record_t   rec;
    logic                room;

    // The configuration registers feed the parser directly, so a table write
    // applies to every byte parsed after it.
    bidf_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The parser holds one input byte and the instruction state, and steps once
    // per byte whenever the result register has room or the byte ends no instruction.
    bidf_parser u_parser
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .stream_valid (stream_valid),
        .stream_ready (stream_ready),
        .stream_byte  (stream_byte),
        .cfg          (cfg),
        .room         (room),
        .push         (push)
    );

    // The result register separates the receiver's stall from the parser.
    bidf_outreg u_outreg
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .room         (room),
        .record_valid (record_valid),
        .record_ready (record_ready),
        .rec          (rec)
    );

    assign opcode = rec.opcode;
    assign arg_count = rec.arg_count;
    assign kind_a = rec.kind_a;
    assign value_a = rec.value_a;
    assign kind_b = rec.kind_b;
    assign value_b = rec.value_b;
    assign kind_c = rec.kind_c;
    assign value_c = rec.value_c;
    assign bad_opcode = rec.bad_opcode;

endmodule
